FILE: hdl/assert_macros.svh
// Assertion macros used by the formatter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/fsip_pkg.sv
// Shared types, character codes and defaults for the integer format printer.
`timescale 1ns / 1ps
`default_nettype none
package fsip_pkg;

    localparam int DecDigitsDef = 10;
    localparam int HexDigitsDef = 8;
    localparam int MaxWidthDef  = 8;
    localparam int CountBitsDef = 16;

    localparam int CharW   = 8;
    localparam int ArgW    = 32;
    localparam int TotalW  = 16;
    localparam int WidthW  = 4;
    localparam int PlacesW = 4;

    localparam logic [CharW-1:0] ChNul       = 8'h00;
    localparam logic [CharW-1:0] ChLf        = 8'h0A;
    localparam logic [CharW-1:0] ChCr        = 8'h0D;
    localparam logic [CharW-1:0] ChSpace     = 8'h20;
    localparam logic [CharW-1:0] ChPct       = 8'h25;
    localparam logic [CharW-1:0] ChMinus     = 8'h2D;
    localparam logic [CharW-1:0] ChZero      = 8'h30;
    localparam logic [CharW-1:0] ChOne       = 8'h31;
    localparam logic [CharW-1:0] ChAlphaBase = 8'h37;   // 'A' - 10
    localparam logic [CharW-1:0] ChUpD       = 8'h44;
    localparam logic [CharW-1:0] ChUpS       = 8'h53;
    localparam logic [CharW-1:0] ChUpX       = 8'h58;
    localparam logic [CharW-1:0] ChLowD      = 8'h64;
    localparam logic [CharW-1:0] ChLowS      = 8'h73;
    localparam logic [CharW-1:0] ChLowX      = 8'h78;

    typedef struct packed {
        logic [CharW-1:0] format_char;
        logic [ArgW-1:0]  arg_value;
    } t_in_item;

    typedef struct packed {
        logic [CharW-1:0]  out_char;
        logic              last_of_run;
        logic [TotalW-1:0] total_count;
    } t_out_item;

    typedef struct packed {
        logic load_dec;
        logic load_hex;
        logic advance;
    } t_conv_ctl;

    typedef struct packed {
        logic [CharW-1:0]   lead_char;
        logic               lead_nz;
        logic [PlacesW-1:0] places;
        logic               busy;
    } t_conv_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT1,
        S_CONV,
        S_SKIP,
        S_PAD,
        S_SIGN,
        S_DIGIT
    } t_state;

endpackage
`default_nettype wire

FILE: hdl/fsip_conv.sv
// Digit register: bit-serial binary to BCD for decimal, nibble load for hex, digit shift-out.
`timescale 1ns / 1ps
`default_nettype none
module fsip_conv
    import fsip_pkg::*;
#(
    parameter int DEC_DIGITS = DecDigitsDef,
    parameter int HEX_DIGITS = HexDigitsDef
) (
    input  wire  logic            i_clk,
    input  wire  logic            i_rst_n,
    input  wire  t_conv_ctl       i_ctl,
    input  wire  logic [ArgW-1:0] i_arg,
    output t_conv_stat            o_stat
);

    localparam int NPL      = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_N    = (NPL > 1) ? NPL - 1 : 1;
    localparam int DEC_LOW  = DEC_DIGITS - 1;
    localparam int HEX_LOW  = HEX_DIGITS - 1;
    localparam int DEC_BASE = DIG_N - DEC_LOW;
    localparam int HEX_BASE = DIG_N - HEX_LOW;
    localparam int HEX_SH   = 4 * (HEX_DIGITS - 1);
    localparam int CNT_W    = $clog2(ArgW + 1);

    // Lower places sit at the low indices of the register; place below the lead is DIG_N-1.
    logic [3:0]         r_dig [DIG_N];
    logic [3:0]         n_dig [DIG_N];
    logic [3:0]         adj   [DIG_N];
    logic [DIG_N:0]     cy;
    logic [CharW-1:0]   r_lead,    n_lead;
    logic               r_lead_nz, n_lead_nz;
    logic               r_alpha,   n_alpha;
    logic [PlacesW-1:0] r_places,  n_places;
    logic [ArgW-1:0]    r_mag,     n_mag;
    logic [CNT_W-1:0]   r_cnt,     n_cnt;
    logic [ArgW-1:0]    hex_q;
    logic               lead_cin;

    assign hex_q = i_arg >> HEX_SH;

    always_comb begin
        // add-3 correction is per digit, carries only cross the shift
        cy[0] = 1'b0;
        for (int i = 0; i < DIG_N; i++) begin
            adj[i]  = (r_dig[i] >= 4'd5) ? r_dig[i] + 4'd3 : r_dig[i];
            cy[i+1] = adj[i][3];
        end
        lead_cin = (DEC_LOW == 0) ? r_mag[ArgW-1] : cy[DIG_N];

        n_dig     = r_dig;
        n_lead    = r_lead;
        n_lead_nz = r_lead_nz;
        n_alpha   = r_alpha;
        n_places  = r_places;
        n_mag     = r_mag;
        n_cnt     = r_cnt;

        if (i_ctl.load_dec) begin
            for (int i = 0; i < DIG_N; i++) begin
                n_dig[i] = 4'd0;
            end
            n_lead    = '0;
            n_lead_nz = 1'b0;
            n_alpha   = 1'b0;
            n_places  = PlacesW'(DEC_DIGITS);
            n_mag     = i_arg[ArgW-1] ? ArgW'(0 - i_arg) : i_arg;
            n_cnt     = CNT_W'(ArgW);
        end else if (i_ctl.load_hex) begin
            for (int i = 0; i < DIG_N; i++) begin
                n_dig[i] = (i >= HEX_BASE) ?
                           i_arg[4*((i >= HEX_BASE) ? i - HEX_BASE : 0) +: 4] : 4'd0;
            end
            n_lead    = hex_q[CharW-1:0];
            n_lead_nz = |hex_q;
            n_alpha   = (hex_q >= ArgW'(10));
            n_places  = PlacesW'(HEX_DIGITS);
        end else if (r_cnt != '0) begin
            for (int i = 0; i < DIG_N; i++) begin
                if (i >= DEC_BASE) begin
                    n_dig[i] = {adj[i][2:0], (i == DEC_BASE) ? r_mag[ArgW-1] : cy[i]};
                end
            end
            // leading place keeps the whole high quotient, mod 256
            n_lead    = {r_lead[CharW-2:0], lead_cin};
            n_lead_nz = r_lead_nz | lead_cin;
            n_mag     = {r_mag[ArgW-2:0], 1'b0};
            n_cnt     = r_cnt - CNT_W'(1);
        end else if (i_ctl.advance) begin
            n_lead    = {4'd0, r_dig[DIG_N-1]};
            n_lead_nz = |r_dig[DIG_N-1];
            n_alpha   = (r_dig[DIG_N-1] >= 4'd10);
            n_places  = r_places - PlacesW'(1);
            n_dig[0]  = 4'd0;
            for (int i = 1; i < DIG_N; i++) begin
                n_dig[i] = r_dig[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_places <= '0;
        end else begin
            r_cnt    <= n_cnt;
            r_places <= n_places;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig     <= n_dig;
        r_lead    <= n_lead;
        r_lead_nz <= n_lead_nz;
        r_alpha   <= n_alpha;
        r_mag     <= n_mag;
    end

    assign o_stat.lead_char = r_alpha ? r_lead + ChAlphaBase : r_lead + ChZero;
    assign o_stat.lead_nz   = r_lead_nz;
    assign o_stat.places    = r_places;
    assign o_stat.busy      = (r_cnt != '0);

endmodule
`default_nettype wire

FILE: hdl/format_string_integer_printer.sv
// Format-string integer printer top level: parser, sequencer and output register.
// Takes one format byte with a 32-bit argument per item and writes output bytes one per
// cycle into an output register. A plain byte, newline or terminating NUL is accepted,
// then written. A hex conversion loads the digit register, drops leading zeros (at most
// HEX_DIGITS-1) and sizes the pad, then writes its bytes. A decimal conversion first runs
// a bit-serial binary-to-BCD conversion (one argument bit per cycle through the digit
// register, then a hand-over) before the same steps. Flags, widths, '%' and 's' write
// nothing. A new item is taken only when the sequencer has gone back to idle; a stalled
// sink stretches every byte write.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module format_string_integer_printer
    import fsip_pkg::*;
#(
    parameter int DEC_DIGITS = DecDigitsDef,
    parameter int HEX_DIGITS = HexDigitsDef,
    parameter int MAX_WIDTH  = MaxWidthDef,
    parameter int COUNT_BITS = CountBitsDef
) (
    input  wire  logic     i_clk,
    input  wire  logic     i_rst_n,
    input  wire  logic     i_in_valid,
    output logic           o_in_ready,
    input  wire  t_in_item i_in_item,
    output logic           o_out_valid,
    input  wire  logic     i_out_ready,
    output t_out_item      o_out_item
);

    typedef enum logic [2:0] {
        A_NUL,
        A_WIDTH,
        A_OPEN,
        A_ZPAD,
        A_DEC,
        A_HEX,
        A_STR,
        A_CHAR
    } t_act;

    localparam logic [CharW-1:0]      WidthTop = CharW'(ChZero + MAX_WIDTH);
    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    t_state                r_state, n_state;
    logic                  r_in_conv;
    logic                  r_zero_pad;
    logic [WidthW-1:0]     r_width;
    logic [COUNT_BITS-1:0] r_count;
    logic [CharW-1:0]      r_char;
    logic [TotalW-1:0]     r_total;
    logic                  r_neg;
    logic [WidthW-1:0]     r_pad;
    logic                  r_ov;
    t_out_item             r_out;

    logic                  in_accept;
    logic                  slot;
    logic [CharW-1:0]      c;
    logic [CharW-1:0]      d_char;
    t_act                  d_act;
    logic [WidthW-1:0]     len;
    logic [WidthW-1:0]     pad_calc;
    logic                  more_zeros;
    logic                  emit;
    logic [CharW-1:0]      e_char;
    logic                  e_last;
    logic [TotalW-1:0]     e_total;
    logic [COUNT_BITS-1:0] total_sat;
    t_conv_ctl             conv_ctl;
    t_conv_stat            conv_stat;

    fsip_conv #(
        .DEC_DIGITS (DEC_DIGITS),
        .HEX_DIGITS (HEX_DIGITS)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (conv_ctl),
        .i_arg   (i_in_item.arg_value),
        .o_stat  (conv_stat)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign slot       = !r_ov || i_out_ready;

    // format byte decode, in priority order
    always_comb begin
        c      = i_in_item.format_char;
        d_char = (c == ChLf) ? ChCr : c;
        if (c == ChNul) begin
            d_act = A_NUL;
        end else if (r_in_conv && c >= ChOne && c <= WidthTop) begin
            d_act = A_WIDTH;
        end else if (c == ChPct) begin
            d_act = A_OPEN;
        end else if (r_in_conv && c == ChZero) begin
            d_act = A_ZPAD;
        end else if (r_in_conv && (c == ChLowD || c == ChUpD)) begin
            d_act = A_DEC;
        end else if (r_in_conv && (c == ChLowX || c == ChUpX)) begin
            d_act = A_HEX;
        end else if (r_in_conv && (c == ChLowS || c == ChUpS)) begin
            d_act = A_STR;
        end else begin
            d_act = A_CHAR;
        end
    end

    // pad goes in front of the sign
    assign len        = WidthW'(r_neg) + conv_stat.places;
    assign pad_calc   = (r_width > len) ? r_width - len : '0;
    assign more_zeros = (conv_stat.places > PlacesW'(1)) && !conv_stat.lead_nz;
    assign total_sat  = (r_count != CountMax) ? r_count + COUNT_BITS'(1) : r_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (d_act) inside
                        A_NUL, A_CHAR: n_state = S_EMIT1;
                        A_DEC:         n_state = S_CONV;
                        A_HEX:         n_state = S_SKIP;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_EMIT1: begin
                if (slot) n_state = S_IDLE;
            end
            S_CONV: begin
                if (!conv_stat.busy) n_state = S_SKIP;
            end
            S_SKIP: begin
                if (!more_zeros) begin
                    if (pad_calc != '0) n_state = S_PAD;
                    else if (r_neg)     n_state = S_SIGN;
                    else                n_state = S_DIGIT;
                end
            end
            S_PAD: begin
                if (slot && r_pad == WidthW'(1)) n_state = r_neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                if (slot) n_state = S_DIGIT;
            end
            S_DIGIT: begin
                if (slot && conv_stat.places == PlacesW'(1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        emit     = 1'b0;
        e_char   = r_char;
        e_last   = 1'b0;
        e_total  = '0;
        conv_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                conv_ctl.load_dec = in_accept && (d_act == A_DEC);
                conv_ctl.load_hex = in_accept && (d_act == A_HEX);
            end
            S_EMIT1: begin
                emit    = slot;
                e_last  = 1'b1;
                e_total = r_total;
            end
            S_CONV: begin
                emit = 1'b0;
            end
            S_SKIP: begin
                conv_ctl.advance = more_zeros;
            end
            S_PAD: begin
                emit   = slot;
                e_char = r_zero_pad ? ChZero : ChSpace;
            end
            S_SIGN: begin
                emit   = slot;
                e_char = ChMinus;
            end
            S_DIGIT: begin
                emit             = slot;
                e_char           = conv_stat.lead_char;
                e_last           = (conv_stat.places == PlacesW'(1));
                conv_ctl.advance = slot && (conv_stat.places > PlacesW'(1));
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_conv  <= 1'b0;
            r_zero_pad <= 1'b0;
            r_width    <= '0;
            r_count    <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                case (d_act)
                    A_NUL: begin
                        r_in_conv  <= 1'b0;
                        r_zero_pad <= 1'b0;
                        r_width    <= '0;
                        r_count    <= '0;
                    end
                    A_WIDTH: r_width <= WidthW'(c - ChZero);
                    A_OPEN: begin
                        r_in_conv  <= 1'b1;
                        r_zero_pad <= 1'b0;
                        r_width    <= '0;
                    end
                    A_ZPAD:               r_zero_pad <= 1'b1;
                    A_DEC, A_HEX, A_STR:  r_in_conv  <= 1'b0;
                    default:              r_in_conv  <= r_in_conv;
                endcase
            end else if (emit && !(r_state == S_EMIT1 && r_char == ChNul)
                         && r_count != CountMax) begin
                r_count <= r_count + COUNT_BITS'(1);
            end
            if (emit)             r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_char  <= (d_act == A_NUL) ? ChNul : d_char;
            r_total <= (d_act == A_NUL) ? TotalW'(total_sat) : '0;
            r_neg   <= (d_act == A_DEC) && i_in_item.arg_value[ArgW-1];
        end
        if (r_state == S_SKIP && n_state != S_SKIP) begin
            r_pad <= pad_calc;
        end else if (r_state == S_PAD && emit) begin
            r_pad <= r_pad - WidthW'(1);
        end
        if (emit) begin
            r_out.out_char    <= e_char;
            r_out.last_of_run <= e_last;
            r_out.total_count <= e_total;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    `ASSERT_IMPL(a_total_only_nul, i_clk, i_rst_n, r_ov && (r_out.total_count != '0), r_out.out_char == ChNul, "byte count on a non-terminator item")
    `ASSERT_IMPL(a_busy_in_conv, i_clk, i_rst_n, conv_stat.busy, r_state == S_CONV, "digit conversion running outside conversion state")
    `ASSERT_IMPL(a_pad_nonzero, i_clk, i_rst_n, r_state == S_PAD, r_pad != '0, "pad state with no pad left")
    `ASSERT_NEXT(a_dec_starts, i_clk, i_rst_n, in_accept && (d_act == A_DEC), conv_stat.busy && (r_state == S_CONV), "decimal conversion did not start")
    `ASSERT_IMPL(a_skip_exit, i_clk, i_rst_n, (r_state == S_SKIP) && (n_state != S_SKIP), conv_stat.lead_nz || (conv_stat.places == PlacesW'(1)), "left zero skip on a zero digit")

endmodule
`default_nettype wire

FILE: bench/format_string_integer_printer_chk.sv
// Checker for the integer format printer: predicts each output byte and compares it.
`timescale 1ns / 1ps
module format_string_integer_printer_chk
    import fsip_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_mismatches,
    output int        o_pending
);

    localparam logic [TotalW-1:0] CountSat   = '1;

    // formatter state as the block should hold it
    logic               conv_open     = 1'b0;
    logic               pad_zero      = 1'b0;
    logic [WidthW-1:0]  field_width   = '0;
    logic [TotalW-1:0]  bytes_written = '0;

    t_out_item expected_bytes[$];
    int        mismatches = 0;
    int        pending    = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = pending;

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    function automatic void queue_byte(logic [CharW-1:0] ch, logic last);
        expected_bytes.push_back('{out_char: ch, last_of_run: last, total_count: '0});
        if (bytes_written != CountSat) begin
            bytes_written++;
        end
    endfunction

    function automatic void predict_format_byte(t_in_item item);
        logic [CharW-1:0] ch;
        logic [ArgW-1:0]  mag;
        logic [CharW-1:0] text[$];
        logic [3:0]       nib;
        int               pads;
        ch = item.format_char;

        if (ch == ChNul) begin
            expected_bytes.push_back('{
                out_char:    ChNul,
                last_of_run: 1'b1,
                total_count: (bytes_written == CountSat) ? CountSat : bytes_written + 1'b1
            });
            conv_open     = 1'b0;
            pad_zero      = 1'b0;
            field_width   = '0;
            bytes_written = '0;
            return;
        end

        if (conv_open && ch >= ChOne && ch <= ChZero + MaxWidthDef) begin
            field_width = WidthW'(ch - ChZero);
        end else if (ch == ChPct) begin
            conv_open   = 1'b1;
            pad_zero    = 1'b0;
            field_width = '0;
        end else if (conv_open && ch == ChZero) begin
            pad_zero = 1'b1;
        end else if (conv_open && (ch == ChLowD || ch == ChUpD)) begin
            // magnitude of the most negative value still fits as unsigned
            mag = item.arg_value[ArgW-1] ? -item.arg_value : item.arg_value;
            do begin
                text.push_front(CharW'(ChZero + mag % 10));
                mag = mag / 10;
            end while (mag != 0);
            if (item.arg_value[ArgW-1]) begin
                text.push_front(ChMinus);
            end
        end else if (conv_open && (ch == ChLowX || ch == ChUpX)) begin
            mag = item.arg_value;
            do begin
                nib = mag[3:0];
                text.push_front((nib < 10) ? CharW'(ChZero + nib) : CharW'(ChAlphaBase + nib));
                mag = mag >> 4;
            end while (mag != 0);
        end else if (conv_open && (ch == ChLowS || ch == ChUpS)) begin
            conv_open = 1'b0;
        end else if (ch == ChLf) begin
            text.push_back(ChCr);
        end else begin
            text.push_back(ch);
        end

        // a number closes the conversion and gets left-padded, pad ahead of the sign
        if (conv_open && (ch == ChLowD || ch == ChUpD || ch == ChLowX || ch == ChUpX)) begin
            conv_open = 1'b0;
            pads = int'(field_width) - text.size();
            for (int p = 0; p < pads; p++) begin
                text.push_front(pad_zero ? ChZero : ChSpace);
            end
        end

        for (int k = 0; k < text.size(); k++) begin
            queue_byte(text[k], k == text.size() - 1);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    note_mismatch("unexpected byte", '0, 32'(i_out_item.out_char));
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_item.out_char !== want.out_char) begin
                        note_mismatch("out_char", 32'(want.out_char),
                                      32'(i_out_item.out_char));
                    end
                    if (i_out_item.last_of_run !== want.last_of_run) begin
                        note_mismatch("last_of_run", 32'(want.last_of_run),
                                      32'(i_out_item.last_of_run));
                    end
                    if (i_out_item.total_count !== want.total_count) begin
                        note_mismatch("total_count", 32'(want.total_count),
                                      32'(i_out_item.total_count));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_format_byte(i_in_item);
            end
            pending = expected_bytes.size();
        end
    end

endmodule

FILE: bench/format_string_integer_printer_tb.sv
// Testbench top for the integer format printer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module format_string_integer_printer_tb;
    import fsip_pkg::*;

    localparam int RandomItems = 230;
    localparam int LongConvs   = 12;    // full-width hex conversions in one string
    localparam int LongHoldAt  = 120;
    localparam int LongHold    = 150;
    localparam int DrainCycles = 64;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      fmt_valid  = 1'b0;
    t_in_item  fmt_item   = '0;
    logic      sink_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    int mismatches;
    int pending;
    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;
    int n_sent    = 0;

    logic [CharW-1:0] conv_codes[6] = '{ChLowD, ChUpD, ChLowX, ChUpX, ChLowS, ChUpS};

    format_string_integer_printer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (fmt_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (fmt_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (sink_ready),
        .o_out_item  (o_out_item)
    );

    format_string_integer_printer_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (fmt_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (fmt_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (sink_ready),
        .i_out_item   (o_out_item),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #36_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_item(input logic [CharW-1:0] ch, input logic [ArgW-1:0] arg);
        int gap;
        gap = src_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            fmt_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        fmt_valid <= 1'b1;
        fmt_item  <= '{format_char: ch, arg_value: arg};
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    // output side: random stalls, plus one long hold-off that backs up the input
    initial begin : sink
        int gap;
        int taken;
        taken = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = sink_idle ? $urandom_range(0, 4) : 0;
            if (taken == LongHoldAt) begin
                gap = LongHold;
            end
            if (gap > 0) begin
                sink_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            sink_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && sink_ready));
            taken++;
        end
    end

    initial begin : source
        int               ntok;
        logic [ArgW-1:0]  arg;
        logic [CharW-1:0] ch;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: plain bytes, newline, every conversion, padding and the odd cases
        send_item("A", 32'h0);
        send_item(8'hFF, 32'hFFFF_FFFF);
        send_item("5", 32'h0);
        send_item(ChLf, 32'h0);
        send_item(ChPct, 32'h0);
        send_item(ChLowD, 32'h0);
        send_item(ChPct, 32'h0);
        send_item(ChUpD, 32'h8000_0000);
        send_item(ChPct, 32'h0);
        send_item(ChZero, 32'h0);
        send_item(CharW'(ChZero + 8), 32'h0);
        send_item(ChLowD, 32'hFFFF_FFFB);
        send_item(ChPct, 32'h0);
        send_item(CharW'(ChZero + 3), 32'h0);
        send_item(ChLowX, 32'h1);
        send_item(ChPct, 32'h0);
        send_item(ChUpX, 32'hFFFF_FFFF);
        send_item(ChPct, 32'h0);
        send_item(ChLowS, 32'h0);
        // literal and newline inside an open conversion, then an out-of-range width
        send_item(ChPct, 32'h0);
        send_item("q", 32'h0);
        send_item(ChLf, 32'h0);
        send_item("9", 32'h0);
        send_item(ChUpD, 32'h7FFF_FFFF);
        send_item(ChNul, 32'hFFFF_FFFF);

        // random strings, mostly well-formed conversions
        while (n_sent < RandomItems) begin
            src_idle  = $urandom_range(0, 4) != 0;
            sink_idle = $urandom_range(0, 4) != 0;
            ntok = $urandom_range(1, 6);
            for (int t = 0; t < ntok; t++) begin
                case ($urandom_range(0, 3) == 0 ? 1'b0 : 1'b1)
                    1'b1: begin
                        case ($urandom_range(0, 5))
                            0:       arg = $urandom;
                            1:       arg = $urandom_range(0, 99);
                            2:       arg = 32'd0 - $urandom_range(1, 99);
                            3:       arg = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                            4:       arg = 32'h1 << $urandom_range(0, 31);
                            default: arg = $urandom >> $urandom_range(0, 31);
                        endcase
                        send_item(ChPct, $urandom);
                        if ($urandom_range(0, 2) == 0) begin
                            send_item(ChZero, $urandom);
                        end
                        if ($urandom_range(0, 1) == 1) begin
                            send_item(CharW'(ChZero + $urandom_range(1, 9)), $urandom);
                        end
                        if ($urandom_range(0, 7) == 0) begin
                            // broken sequence: junk byte while the conversion is open
                            send_item(CharW'($urandom_range(1, 255)), $urandom);
                        end
                        send_item(conv_codes[$urandom_range(0, 5)], arg);
                    end
                    default: begin
                        ch = $urandom_range(0, 5) == 0 ? ChLf : CharW'($urandom_range(1, 255));
                        send_item(ch, $urandom);
                    end
                endcase
            end
            send_item(ChNul, $urandom);
        end

        // one long string of full-width hex conversions with no idle cycles
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        for (int i = 0; i < LongConvs; i++) begin
            send_item(ChPct, 32'h0);
            send_item(ChUpX, $urandom | 32'h1000_0000);
        end
        send_item(ChNul, 32'h0);
        // count must restart after a long string
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_item("A", 32'h0);
        send_item(ChNul, 32'h0);
        fmt_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
